[rtl/bgtpf_pkg.sv]
// Shared types and constants for the background tile pixel fetcher.
// No dependencies; used by every module under rtl/ except bgtpf_ram.
`default_nettype none

package bgtpf_pkg;

    // Action codes carried in each input word
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    // Fetcher phases
    typedef enum logic [1:0] {
        PH_TILE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_PUSH = 2'd3
    } phase_t;

    // Display control bit positions
    localparam int unsigned LCDC_BG_ON    = 0;
    localparam int unsigned LCDC_BG_MAP   = 3;
    localparam int unsigned LCDC_UNSIGNED = 4;
    localparam int unsigned LCDC_WIN_ON   = 5;
    localparam int unsigned LCDC_WIN_MAP  = 6;

    // Video memory offsets, counted from 0x8000
    localparam int unsigned VRAM_AW = 13;
    localparam logic [VRAM_AW-1:0] MAP0_OFS        = 13'h1800;
    localparam logic [VRAM_AW-1:0] MAP1_OFS        = 13'h1C00;
    localparam logic [VRAM_AW-1:0] SIGNED_BASE_OFS = 13'h1000;

    typedef struct packed {
        logic [1:0]  action;
        logic [12:0] vram_index;
        logic [7:0]  vram_value;
        logic [7:0]  lcd_control;
        logic [7:0]  scroll_y;
        logic [7:0]  line_y;
        logic [7:0]  window_x;
        logic [7:0]  window_y;
        logic        fifo_empty;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel_row;
        logic [7:0]  tile_column;
    } out_item_t;

    // Fetcher context handed to the address generator
    typedef struct packed {
        phase_t     phase;
        logic [7:0] column;
        logic [7:0] tile_number;
    } fetch_ctx_t;

endpackage

`default_nettype wire

[rtl/background_tile_pixel_fetcher.sv]
// Top level of the background tile pixel fetcher: phase sequencer, video memory, result queue.
// Depends on bgtpf_pkg, bgtpf_ram, bgtpf_addr and bgtpf_outq.
//
//  channel | ports                        | word
//  --------+------------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data     | action, write index/value, LCD regs
//  result  | m_valid, m_ready, m_data     | pixel_row, tile_column
//
// One input word per cycle while s_ready is high; a tick, write or restart never waits on the memory.
// Memory reads issue on the second tick of a phase; the data lands in the next cycle
// and is forwarded to a push that follows directly.
// s_ready drops only while two result words sit unclaimed in the queue.
// Reset clears the sequencer and queue; video memory is not cleared (undefined until written).
`default_nettype none

module background_tile_pixel_fetcher #(
    parameter int unsigned VRAM_DEPTH = 8192
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bgtpf_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bgtpf_pkg::out_item_t      m_data
);

    localparam int unsigned ADDR_W = $clog2(VRAM_DEPTH);

    bgtpf_pkg::phase_t phase_reg, phase_next;
    logic       second_reg, second_next;
    logic [7:0] column_reg, column_next;
    logic [7:0] tile_reg, low_reg, high_reg;
    logic       ld_tile_reg, ld_low_reg, ld_high_reg;

    logic       accept;
    logic       full;
    logic       is_tick;
    logic       bg_on;
    bgtpf_pkg::action_t act;
    logic       rd_tile, rd_low, rd_high;
    logic       push;
    logic       ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0] ram_rdata;
    logic [bgtpf_pkg::VRAM_AW-1:0] rd_addr;
    logic [7:0] eff_tile, eff_low, eff_high;
    logic [15:0] pixels;
    bgtpf_pkg::fetch_ctx_t ctx;
    bgtpf_pkg::out_item_t  result;

    always_comb begin
        s_ready  = !full;
        accept   = s_valid && s_ready;
        act      = bgtpf_pkg::action_t'(s_data.action);
        is_tick  = accept && (act == bgtpf_pkg::ACT_TICK);
        bg_on    = s_data.lcd_control[bgtpf_pkg::LCDC_BG_ON];
        // forward read data that has not yet been captured
        eff_tile = ld_tile_reg ? ram_rdata : tile_reg;
        eff_low  = ld_low_reg  ? ram_rdata : low_reg;
        eff_high = ld_high_reg ? ram_rdata : high_reg;
        ctx.phase       = phase_reg;
        ctx.column      = column_reg;
        ctx.tile_number = eff_tile;
    end

    // Next state
    always_comb begin
        phase_next  = phase_reg;
        second_next = second_reg;
        column_next = column_reg;
        if (accept) begin
            unique case (act)
                bgtpf_pkg::ACT_TICK: begin
                    unique case (phase_reg)
                        bgtpf_pkg::PH_TILE: begin
                            if (!second_reg) begin
                                second_next = 1'b1;
                            end else if (bg_on) begin
                                phase_next  = bgtpf_pkg::PH_LOW;
                                second_next = 1'b0;
                            end
                        end
                        bgtpf_pkg::PH_LOW: begin
                            if (!second_reg) begin
                                second_next = 1'b1;
                            end else begin
                                phase_next  = bgtpf_pkg::PH_HIGH;
                                second_next = 1'b0;
                            end
                        end
                        bgtpf_pkg::PH_HIGH: begin
                            if (!second_reg) begin
                                second_next = 1'b1;
                            end else begin
                                phase_next  = bgtpf_pkg::PH_PUSH;
                                second_next = 1'b0;
                            end
                        end
                        bgtpf_pkg::PH_PUSH: begin
                            if (s_data.fifo_empty) begin
                                phase_next  = bgtpf_pkg::PH_TILE;
                                second_next = 1'b0;
                                column_next = column_reg + 8'd1;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                bgtpf_pkg::ACT_RESTART: begin
                    phase_next  = bgtpf_pkg::PH_TILE;
                    second_next = 1'b0;
                    column_next = 8'd0;
                end
                bgtpf_pkg::ACT_WRITE: begin
                    phase_next = phase_reg;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Outputs of the sequencer
    always_comb begin
        rd_tile = is_tick && (phase_reg == bgtpf_pkg::PH_TILE) && second_reg && bg_on;
        rd_low  = is_tick && (phase_reg == bgtpf_pkg::PH_LOW) && second_reg;
        rd_high = is_tick && (phase_reg == bgtpf_pkg::PH_HIGH) && second_reg;
        push    = is_tick && (phase_reg == bgtpf_pkg::PH_PUSH) && s_data.fifo_empty;
        ram_we  = accept && (act == bgtpf_pkg::ACT_WRITE);
        ram_addr = ram_we ? ADDR_W'(s_data.vram_index) : ADDR_W'(rd_addr);
        for (int i = 0; i < 8; i++) begin
            pixels[2*i]   = eff_low[i] && bg_on;
            pixels[2*i+1] = eff_high[i] && bg_on;
        end
        result.pixel_row   = pixels;
        result.tile_column = column_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= bgtpf_pkg::PH_TILE;
            second_reg  <= 1'b0;
            column_reg  <= 8'd0;
            tile_reg    <= 8'd0;
            low_reg     <= 8'd0;
            high_reg    <= 8'd0;
            ld_tile_reg <= 1'b0;
            ld_low_reg  <= 1'b0;
            ld_high_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            second_reg  <= second_next;
            column_reg  <= column_next;
            tile_reg    <= eff_tile;
            low_reg     <= eff_low;
            high_reg    <= eff_high;
            ld_tile_reg <= rd_tile;
            ld_low_reg  <= rd_low;
            ld_high_reg <= rd_high;
        end
    end

    bgtpf_addr u_addr (
        .item    (s_data),
        .ctx     (ctx),
        .rd_addr (rd_addr)
    );

    bgtpf_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data.vram_value),
        .rdata (ram_rdata)
    );

    bgtpf_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (result),
        .full      (full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef ASSERT_OFF
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ld_tile_reg, ld_low_reg, ld_high_reg}))
        else $error("more than one memory load pending");
    a_tile_load_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_tile_reg |-> phase_reg == bgtpf_pkg::PH_LOW)
        else $error("tile number load outside low byte phase");
    a_high_load_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_high |=> ld_high_reg && phase_reg == bgtpf_pkg::PH_PUSH)
        else $error("high byte read did not lead to push phase");
`endif

endmodule

`default_nettype wire

[rtl/bgtpf_ram.sv]
// Generic single-port synchronous RAM, read-first, registered read data.
// No dependencies.
`default_nettype none

module bgtpf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/bgtpf_addr.sv]
// Video memory read address for the current fetch phase: tile map entry or tile row byte.
// Depends on bgtpf_pkg.
`default_nettype none

module bgtpf_addr (
    input  wire bgtpf_pkg::in_item_t   item,
    input  wire bgtpf_pkg::fetch_ctx_t ctx,
    output logic [bgtpf_pkg::VRAM_AW-1:0] rd_addr
);

    logic [7:0]  wxm7;
    logic        win_above;
    logic [10:0] col_px;
    logic        win_tile;
    logic        win_data;
    logic [7:0]  win_dy;
    logic [7:0]  bg_dy;
    logic [4:0]  tile_y;
    logic        map_sel;
    logic [2:0]  fine_y;
    logic [bgtpf_pkg::VRAM_AW-1:0] map_addr;
    logic [bgtpf_pkg::VRAM_AW-1:0] tile_base;
    logic [bgtpf_pkg::VRAM_AW-1:0] row_addr;

    always_comb begin
        wxm7      = item.window_x - 8'd7;
        win_above = item.window_y <= item.line_y;
        col_px    = {ctx.column, 3'b000};
        // tile stage compares against wrapped wx-7, data stages against the signed one
        win_tile  = item.lcd_control[bgtpf_pkg::LCDC_WIN_ON] && win_above &&
                    (col_px >= {3'b000, wxm7});
        win_data  = item.lcd_control[bgtpf_pkg::LCDC_WIN_ON] && win_above &&
                    (({1'b0, col_px} + 12'd7) >= {4'b0000, item.window_x});
        win_dy    = item.line_y - item.window_y;
        bg_dy     = item.scroll_y + item.line_y;

        tile_y   = win_tile ? win_dy[7:3] : bg_dy[7:3];
        map_sel  = win_tile ? item.lcd_control[bgtpf_pkg::LCDC_WIN_MAP]
                            : item.lcd_control[bgtpf_pkg::LCDC_BG_MAP];
        map_addr = (map_sel ? bgtpf_pkg::MAP1_OFS : bgtpf_pkg::MAP0_OFS) +
                   {3'b000, tile_y, 5'b00000} + {5'b00000, ctx.column};

        fine_y = win_data ? win_dy[2:0] : bg_dy[2:0];
        if (item.lcd_control[bgtpf_pkg::LCDC_UNSIGNED]) begin
            tile_base = {1'b0, ctx.tile_number, 4'b0000};
        end else begin
            tile_base = bgtpf_pkg::SIGNED_BASE_OFS +
                        {ctx.tile_number[7], ctx.tile_number, 4'b0000};
        end
        row_addr = tile_base + {9'd0, fine_y, 1'b0} +
                   {12'd0, ctx.phase == bgtpf_pkg::PH_HIGH};

        rd_addr = (ctx.phase == bgtpf_pkg::PH_TILE) ? map_addr : row_addr;
    end

endmodule

`default_nettype wire

[rtl/bgtpf_outq.sv]
// Two-word result queue decoupling the fetcher from the result channel.
// Depends on bgtpf_pkg.
`default_nettype none

module bgtpf_outq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire bgtpf_pkg::out_item_t push_data,
    output logic                      full,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bgtpf_pkg::out_item_t      m_data
);

    bgtpf_pkg::out_item_t slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       pop;

    always_comb begin
        pop         = m_valid && m_ready;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        full        = count_reg == 2'd2;
        m_valid     = count_reg != 2'd0;
        m_data      = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("result word pushed into full queue");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not grow on push");
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not shrink on pop");
`endif

endmodule

`default_nettype wire
